@@ rtl/sle_pkg.sv @@
// Shared types and character codes for the serial line editor.
`default_nettype none

package sle_pkg;

  localparam logic [7:0] CharBs = 8'h08;
  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;
  localparam logic [7:0] CharSp = 8'h20;
  localparam logic [7:0] MaxLengthReset = 8'd64;

  // Most result items one received character can cause.
  localparam int unsigned MaxItems = 4;
  localparam int unsigned ItemIdxW = $clog2(MaxItems);
  localparam int unsigned ItemCntW = $clog2(MaxItems + 1);

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic       line_done;
    logic [7:0] line_length;
    logic       last;
  } item_t;

  typedef item_t [MaxItems-1:0] item_set_t;

endpackage

`default_nettype wire

@@ rtl/sle_edit.sv @@
// Line editing state and per-character result item generation.
`default_nettype none

module sle_edit import sle_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [7:0]          rx_char_i,
  input  wire logic [7:0]          max_length_i,
  output item_set_t                items_o,
  output logic      [ItemCntW-1:0] count_o
);

  logic [7:0] line_position_q, line_position_d;
  logic [7:0] budget_left_q, budget_left_d;

  always_comb begin
    logic [8:0]          pos;
    logic                done;
    logic [ItemCntW-1:0] n;
    logic [ItemIdxW-1:0] last_idx;
    pos      = {1'b0, line_position_q};
    done     = 1'b0;
    n        = '0;
    last_idx = '0;
    items_o  = '0;

    if (rx_char_i == CharBs) begin
      if (line_position_q != 8'd0) begin
        pos = pos - 9'd1;
        items_o[0].echo_valid = 1'b1;
        items_o[0].echo_byte  = CharBs;
        items_o[1].echo_valid = 1'b1;
        items_o[1].echo_byte  = CharSp;
        items_o[2].echo_valid = 1'b1;
        items_o[2].echo_byte  = CharBs;
        n = ItemCntW'(3);
      end
    end else if (rx_char_i == CharCr) begin
      items_o[0].echo_valid  = 1'b1;
      items_o[0].echo_byte   = CharCr;
      items_o[0].store_valid = 1'b1;
      items_o[0].store_index = line_position_q;
      items_o[0].store_byte  = CharCr;
      items_o[1].echo_valid  = 1'b1;
      items_o[1].echo_byte   = CharLf;
      n    = ItemCntW'(2);
      pos  = pos + 9'd1;
      done = 1'b1;
    end else begin
      items_o[0].echo_valid  = 1'b1;
      items_o[0].echo_byte   = rx_char_i;
      items_o[0].store_valid = 1'b1;
      items_o[0].store_index = line_position_q;
      items_o[0].store_byte  = rx_char_i;
      n   = ItemCntW'(1);
      pos = pos + 9'd1;
    end

    // Budget of one or less left: this character closes the line.
    if (budget_left_q <= 8'd1) done = 1'b1;

    if (done) begin
      // Terminator overwrites the last stored slot; empty line writes none.
      items_o[n[ItemIdxW-1:0]].line_done = 1'b1;
      if (pos != 9'd0) begin
        items_o[n[ItemIdxW-1:0]].store_valid = 1'b1;
        items_o[n[ItemIdxW-1:0]].store_index = 8'(pos - 9'd1);
        items_o[n[ItemIdxW-1:0]].line_length = 8'(pos - 9'd1);
      end
      n = n + ItemCntW'(1);
    end

    if (n != '0) begin
      last_idx = ItemIdxW'(n - ItemCntW'(1));
      items_o[last_idx].last = 1'b1;
    end
    count_o = n;

    if (done) begin
      line_position_d = 8'd0;
      budget_left_d   = max_length_i;
    end else begin
      line_position_d = pos[7:0];
      budget_left_d   = budget_left_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_position_q <= 8'd0;
      budget_left_q   <= MaxLengthReset;
    end else if (accept_i) begin
      line_position_q <= line_position_d;
      budget_left_q   <= budget_left_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/serial_line_editor_echo.sv @@
// Top level of the serial line editor: config register, editor and result queue.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------------
//   in      | request   | in_valid_i/in_stall_o | rx_char_i
//   out     | result    | out_valid_o/out_stall_i | echo, store, line_done/length, last
//   cfg     | write     | cfg_valid_i/cfg_ready_o | cfg_max_length_i
//
// Each request is decoded combinationally into 0..4 result items held in a
// four-entry result register; items leave one per cycle unless out_stall_i
// holds them, and the single output port drains that register.
// A new request is taken in the cycle the last item of the previous one leaves.
// Reset clears line position, loads budget and max_length with 64, empties queue.
// out_stall_i holds the current item; in_stall_o rises while items are pending.
`default_nettype none

module serial_line_editor_echo import sle_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // request channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_char_i,
  // result channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            echo_valid_o,
  output logic [7:0]      echo_byte_o,
  output logic            store_valid_o,
  output logic [7:0]      store_index_o,
  output logic [7:0]      store_byte_o,
  output logic            line_done_o,
  output logic [7:0]      line_length_o,
  output logic            last_o,
  // configuration
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_max_length_i
);

  logic [7:0]          max_length_q;
  item_set_t           items_q, new_items;
  logic [ItemCntW-1:0] count_q, new_count;
  logic [ItemIdxW-1:0] idx_q;
  item_t               cur_item;
  logic                take, last_take, free, accept;

  // Config writes must be issued only while idle; not enforced here, so always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MaxLengthReset;
    end else if (cfg_valid_i) begin
      max_length_q <= cfg_max_length_i;
    end
  end

  // Current head of the result register.
  assign cur_item    = items_q[idx_q];
  assign out_valid_o = (count_q != '0);
  assign take        = out_valid_o && !out_stall_i;
  assign last_take   = take && cur_item.last;
  // Queue is free when empty or when its final item leaves now.
  assign free        = !out_valid_o || last_take;
  assign in_stall_o  = !free;
  assign accept      = in_valid_i && free;

  sle_edit u_edit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .rx_char_i    (rx_char_i),
    .max_length_i (max_length_q),
    .items_o      (new_items),
    .count_o      (new_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else if (accept) begin
      count_q <= new_count;
      idx_q   <= '0;
    end else if (last_take) begin
      count_q <= '0;
      idx_q   <= '0;
    end else if (take) begin
      idx_q   <= idx_q + ItemIdxW'(1);
    end
  end

  // Payload needs no reset; it only matters while count_q is nonzero.
  always_ff @(posedge clk_i) begin
    if (accept) items_q <= new_items;
  end

  assign echo_valid_o  = cur_item.echo_valid;
  assign echo_byte_o   = cur_item.echo_byte;
  assign store_valid_o = cur_item.store_valid;
  assign store_index_o = cur_item.store_index;
  assign store_byte_o  = cur_item.store_byte;
  assign line_done_o   = cur_item.line_done;
  assign line_length_o = cur_item.line_length;
  assign last_o        = cur_item.last;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ItemCntW'(MaxItems))
    else $error("result count out of range");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_done_o |-> last_o)
    else $error("line end item is not the last item");

  a_accept_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !out_valid_o || (!out_stall_i && last_o))
    else $error("request accepted while results pending");

  a_stall_holds_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(idx_q) && out_valid_o)
    else $error("result index moved during stall");

  a_no_echo_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(echo_valid_o && line_done_o))
    else $error("echo and line end in one item");
`endif

endmodule

`default_nettype wire
